FILE: rtl/core/cspu_pkg.sv
package cspu_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int FRAME_W     = FRAME_BYTES * 8;
    localparam int PHYS_W      = 48;
    localparam int RAW_W       = 57;
    localparam int DIV_STEPS   = RAW_W;
    localparam int CFG_W       = PHYS_W;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    localparam logic [2:0] REG_START_BIT  = 3'd0;
    localparam logic [2:0] REG_BIT_LENGTH = 3'd1;
    localparam logic [2:0] REG_MIN_VALUE  = 3'd2;
    localparam logic [2:0] REG_MAX_VALUE  = 3'd3;
    localparam logic [2:0] REG_BIG_ENDIAN = 3'd4;

    typedef struct packed {
        logic                     command;
        logic [FRAME_W-1:0]       frame_in;
        logic [3:0]               frame_len;
        logic signed [PHYS_W-1:0] physical_in;
    } t_in;

    typedef struct packed {
        logic [FRAME_W-1:0]       frame_out;
        logic signed [PHYS_W-1:0] physical_out;
        logic [1:0]               status;
    } t_out;

    // config reg settings; user must hold static while items in flight, unenforced
    typedef struct packed {
        logic [2:0]               shift;
        logic [2:0]               pos;
        logic [3:0]               covered;
        logic                     be;
        logic [RAW_W-1:0]         mask;
        logic signed [PHYS_W-1:0] lo;
        logic signed [PHYS_W-1:0] hi;
        logic                     range_neg;
        logic [RAW_W-1:0]         r_enc;
        logic [RAW_W-1:0]         ar;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               command;
        logic [FRAME_W-1:0] frame;
        logic [1:0]         status;
        logic [RAW_W-1:0]   d;
        logic [RAW_W-1:0]   rem;
        logic [RAW_W-1:0]   q;
    } t_pipe;

endpackage

FILE: rtl/core/cspu_front.sv
module cspu_front import cspu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_in   i_in,
    input  t_cfg  i_cfg,
    output t_pipe o_pipe
);

    t_pipe              r_pipe;
    t_pipe              n_pipe;
    logic [3:0]         flen;
    logic               fits;
    logic               out_of_range;
    logic [FRAME_W-1:0] word;
    logic [2:0]         idx;
    logic [PHYS_W:0]    diff;

    always_comb begin
        flen = (i_in.frame_len > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : i_in.frame_len;
        out_of_range = i_in.command &&
            (i_in.physical_in > i_cfg.hi || i_in.physical_in < i_cfg.lo);
        if (i_cfg.be) begin
            fits = ({1'b0, i_cfg.pos} < flen) && (i_cfg.covered <= {1'b0, i_cfg.pos} + 4'd1);
        end else begin
            fits = ({1'b0, i_cfg.pos} + i_cfg.covered) <= flen;
        end
        word = '0;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            idx = i_cfg.be ? i_cfg.pos - 3'(k) : i_cfg.pos + 3'(k);
            if (4'(k) < i_cfg.covered) begin
                word[8*k +: 8] = i_in.frame_in[8*idx +: 8];
            end
        end
        diff = {i_in.physical_in[PHYS_W-1], i_in.physical_in}
             - {i_cfg.lo[PHYS_W-1], i_cfg.lo};

        n_pipe.valid   = i_start;
        n_pipe.command = i_in.command;
        n_pipe.frame   = i_in.frame_in;
        if (out_of_range) begin
            n_pipe.status = ST_RANGE;
        end else if (!fits) begin
            n_pipe.status = ST_TRUNC;
        end else begin
            n_pipe.status = ST_OK;
        end
        if (i_in.command) begin
            n_pipe.d = RAW_W'(diff);
        end else begin
            n_pipe.d = RAW_W'(word >> i_cfg.shift) & i_cfg.mask;
        end
        n_pipe.rem = '0;
        n_pipe.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
        end else begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule

FILE: rtl/core/cspu_div_stage.sv
module cspu_div_stage import cspu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [5:0] i_step,
    input  t_cfg       i_cfg,
    input  t_pipe      i_pipe,
    output t_pipe      o_pipe
);

    t_pipe              r_pipe;
    t_pipe              n_pipe;
    logic               m_bit;
    logic [RAW_W-1:0]   div;
    logic [RAW_W+1:0]   t;
    logic [RAW_W+1:0]   r1;
    logic [RAW_W+1:0]   r2;
    logic [RAW_W+1:0]   sub;
    logic [1:0]         qd;

    // one restoring step of floor(d * m / r), m taken msb first
    always_comb begin
        m_bit = i_pipe.command ? i_cfg.mask[i_step] : i_cfg.ar[i_step];
        div   = i_pipe.command ? i_cfg.r_enc : i_cfg.mask;
        t  = {1'b0, i_pipe.rem, 1'b0} + (m_bit ? {2'b0, i_pipe.d} : '0);
        r1 = {2'b0, div};
        r2 = {1'b0, div, 1'b0};
        if (t >= r2) begin
            sub = r2;
            qd  = 2'd2;
        end else if (t >= r1) begin
            sub = r1;
            qd  = 2'd1;
        end else begin
            sub = '0;
            qd  = 2'd0;
        end
        n_pipe     = i_pipe;
        n_pipe.rem = RAW_W'(t - sub);
        n_pipe.q   = {i_pipe.q[RAW_W-2:0], 1'b0} + {{(RAW_W-2){1'b0}}, qd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
        end else begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule

FILE: rtl/core/cspu_back.sv
module cspu_back import cspu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_pipe i_pipe,
    output logic  o_valid,
    output t_out  o_out
);

    logic               r_valid;
    t_out               r_out;
    t_out               n_out;
    logic [FRAME_W-1:0] word;
    logic [FRAME_W-1:0] packed_frame;
    logic [2:0]         idx;
    logic [PHYS_W-1:0]  q48;

    always_comb begin
        word = FRAME_W'(i_pipe.q & i_cfg.mask) << i_cfg.shift;
        packed_frame = i_pipe.frame;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            idx = i_cfg.be ? i_cfg.pos - 3'(k) : i_cfg.pos + 3'(k);
            if (4'(k) < i_cfg.covered) begin
                packed_frame[8*idx +: 8] = packed_frame[8*idx +: 8] | word[8*k +: 8];
            end
        end
        q48 = PHYS_W'(i_pipe.q);

        n_out.status       = i_pipe.status;
        n_out.frame_out    = i_pipe.frame;
        n_out.physical_out = '0;
        if (i_pipe.status == ST_OK) begin
            if (i_pipe.command) begin
                n_out.frame_out = packed_frame;
            end else if (i_cfg.range_neg) begin
                n_out.physical_out = i_cfg.lo - $signed(q48);
            end else begin
                n_out.physical_out = i_cfg.lo + $signed(q48);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_pipe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

FILE: rtl/core/can_signal_pack_unpack_unit.sv
// the result strobe o_valid rises once the accepting edge's item has passed
// one input stage, 57 divider steps of the scaling unit and one output stage
// throughput: one beat per cycle, o_busy stays low; the receiver cannot stall
// reset: synchronous active low, clears all valid bits and loads the default
// signal settings (start bit 0, length 8, range 0.0 to 255.0, little endian)
module can_signal_pack_unpack_unit import cspu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_in              i_in,
    output logic             o_valid,
    output t_out             o_out,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [5:0]              r_start_bit;
    logic [5:0]              r_bit_length;
    logic signed [PHYS_W-1:0] r_min_value;
    logic signed [PHYS_W-1:0] r_max_value;
    logic                    r_big_endian;

    t_cfg                    cfg;
    logic [5:0]              len_c;
    logic [PHYS_W:0]         range49;
    logic [PHYS_W:0]         abs49;
    logic [6:0]              end_bit;
    t_pipe                   w_pipe [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bit  <= '0;
            r_bit_length <= 6'd8;
            r_min_value  <= '0;
            r_max_value  <= PHYS_W'(48'd16711680);
            r_big_endian <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_BIT:  r_start_bit  <= i_cfg_data[5:0];
                REG_BIT_LENGTH: r_bit_length <= i_cfg_data[5:0];
                REG_MIN_VALUE:  r_min_value  <= i_cfg_data;
                REG_MAX_VALUE:  r_max_value  <= i_cfg_data;
                REG_BIG_ENDIAN: r_big_endian <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_bit_length == 6'd0) begin
            len_c = 6'd1;
        end else if (r_bit_length > 6'(RAW_W)) begin
            len_c = 6'(RAW_W);
        end else begin
            len_c = r_bit_length;
        end
        range49 = {r_max_value[PHYS_W-1], r_max_value} - {r_min_value[PHYS_W-1], r_min_value};
        abs49   = range49[PHYS_W] ? (~range49 + 1'b1) : range49;
        end_bit = {1'b0, r_start_bit} + {1'b0, len_c} - 7'd1;

        cfg.shift     = r_start_bit[2:0];
        cfg.pos       = r_start_bit[5:3];
        cfg.covered   = end_bit[6:3] - {1'b0, r_start_bit[5:3]} + 4'd1;
        cfg.be        = r_big_endian;
        cfg.mask      = ~({RAW_W{1'b1}} << len_c);
        cfg.lo        = r_min_value;
        cfg.hi        = r_max_value;
        cfg.range_neg = range49[PHYS_W];
        // equal bounds: divide zero by one so raw comes out zero
        cfg.r_enc     = (!range49[PHYS_W] && range49 != '0) ? RAW_W'(range49) : RAW_W'(1);
        cfg.ar        = RAW_W'(abs49);
    end

    cspu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .o_pipe  (w_pipe[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        cspu_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (6'(RAW_W - 1 - i)),
            .i_cfg   (cfg),
            .i_pipe  (w_pipe[i]),
            .o_pipe  (w_pipe[i+1])
        );
    end

    cspu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pipe  (w_pipe[DIV_STEPS]),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    assign o_busy = 1'b0;

endmodule
